@@ hw/rtl/tcap_pkg.sv @@
package tcap_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 32;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_TRANSITION_ALTITUDE = 2'd0,
      CSR_CRUISE_ALTITUDE     = 2'd1,
      CSR_THROTTLE_CEILING    = 2'd2,
      CSR_UNUSED              = 2'd3
   } csr_index_type;

   typedef enum logic {
      MODE_TAKEOFF = 1'b0,
      MODE_CRUISE  = 1'b1
   } flight_mode_type;

   localparam logic [30:0] RESET_TRANSITION_ALTITUDE = 31'd196608000;
   localparam logic [30:0] RESET_CRUISE_ALTITUDE     = 31'd283967488;
   localparam logic [16:0] RESET_THROTTLE_CEILING    = 17'd39322;

   // q16.16 step sizes and thresholds
   localparam logic signed [31:0] K_0005 = 32'sd33;
   localparam logic signed [31:0] K_0001 = 32'sd7;
   localparam logic signed [31:0] K_001  = 32'sd66;
   localparam logic signed [31:0] K_005  = 32'sd328;
   localparam logic signed [31:0] K_01   = 32'sd655;
   localparam logic signed [31:0] K_TENTH = 32'sd6554;
   localparam logic signed [31:0] K_FIFTH = 32'sd13107;
   localparam logic signed [31:0] K_ONE   = 32'sd65536;
   localparam logic signed [31:0] K_AS120 = 32'sd7864320;
   localparam logic signed [31:0] K_AS121 = 32'sd7929856;

   // gains as q0.32
   localparam logic signed [29:0] ROLL_GAIN = 30'sd429496730;
   localparam logic signed [20:0] ALT_GAIN  = 21'sd644245;

   typedef struct packed {
      logic signed [31:0] sink_speed;
      logic signed [31:0] air_speed;
      logic signed [31:0] north_speed;
      logic signed [31:0] north_accel;
      logic signed [31:0] roll_angle;
      logic signed [31:0] altitude_now;
      logic signed [31:0] aileron_now;
      logic signed [31:0] elevator_now;
      logic signed [31:0] rudder_now;
      logic signed [31:0] throttle_left_now;
      logic signed [31:0] throttle_right_now;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] aileron_cmd;
      logic signed [31:0] elevator_cmd;
      logic signed [31:0] rudder_cmd;
      logic signed [31:0] throttle_left_cmd;
      logic signed [31:0] throttle_right_cmd;
      logic               mode_used;
   } rsp_word_type;

   typedef struct packed {
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [CSR_DATA_WIDTH-1:0]  data;
   } csr_word_type;

   typedef struct packed {
      logic [30:0] transition_altitude;
      logic [30:0] cruise_altitude;
      logic [16:0] throttle_ceiling;
   } cfg_type;

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] sum;
      sum = $signed({a[31], a}) + $signed({b[31], b});
      if (sum[32] != sum[31]) begin
         sat_add = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         sat_add = sum[31:0];
      end
   endfunction

endpackage

@@ hw/rtl/tcap_if.sv @@
interface tcap_req_if;
   logic                  valid;
   logic                  ready;
   tcap_pkg::req_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

interface tcap_rsp_if;
   logic                  valid;
   logic                  ready;
   tcap_pkg::rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

interface tcap_csr_if;
   logic                  valid;
   logic                  ready;
   tcap_pkg::csr_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

@@ hw/rtl/takeoff_cruise_autopilot_step.sv @@
// Takeoff and cruise autopilot step: each request word is one flight-state sample with the
// current control settings, and each yields exactly one response word of new commands, in
// order. A sample is registered on entry, its control laws are evaluated combinationally
// (a multiply each for the roll and altitude laws) into the response register, and one
// sample can be taken every cycle while the response side keeps up. The flight mode bit
// starts in takeoff after reset and switches to cruise for the samples after one whose
// altitude reaches the transition altitude; mode_used reports the rule applied. The csr
// channel is always ready; write it only while no samples are in flight.
module takeoff_cruise_autopilot_step (
   input  logic        clock,
   input  logic        reset,
   tcap_req_if.sink    req_if,
   tcap_rsp_if.source  rsp_if,
   tcap_csr_if.sink    csr_if
);

   tcap_pkg::cfg_type         cfg;
   tcap_pkg::rsp_word_type    law_word;
   logic                      to_cruise;

   logic                      s1_valid_ff;
   logic                      s1_valid_in;
   tcap_pkg::req_word_type    s1_word_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   tcap_pkg::rsp_word_type    rsp_word_ff;
   tcap_pkg::flight_mode_type mode_ff;
   tcap_pkg::flight_mode_type mode_in;
   logic                      s1_advance;
   logic                      req_take;

   tcap_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   tcap_law u_law (
      .mode      (mode_ff),
      .req_word  (s1_word_ff),
      .cfg       (cfg),
      .rsp_word  (law_word),
      .to_cruise (to_cruise)
   );

   assign s1_advance   = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || s1_advance;
   assign req_take     = req_if.valid && req_if.ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = s1_advance || (rsp_valid_ff && !rsp_if.ready);
   assign mode_in      = (s1_advance && to_cruise) ? tcap_pkg::MODE_CRUISE : mode_ff;

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.word  = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= tcap_pkg::MODE_TAKEOFF;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_word_ff <= req_if.word;
      end
      if (s1_advance) begin
         rsp_word_ff <= law_word;
      end
   end

endmodule

@@ hw/rtl/tcap_csr.sv @@
module tcap_csr (
   input  logic              clock,
   input  logic              reset,
   tcap_csr_if.sink          csr_if,
   output tcap_pkg::cfg_type cfg
);

   tcap_pkg::cfg_type cfg_ff;
   tcap_pkg::cfg_type cfg_in;

   assign csr_if.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (tcap_pkg::csr_index_type'(csr_if.word.index))
            tcap_pkg::CSR_TRANSITION_ALTITUDE: cfg_in.transition_altitude = csr_if.word.data[30:0];
            tcap_pkg::CSR_CRUISE_ALTITUDE:     cfg_in.cruise_altitude = csr_if.word.data[30:0];
            tcap_pkg::CSR_THROTTLE_CEILING:    cfg_in.throttle_ceiling = csr_if.word.data[16:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.transition_altitude <= tcap_pkg::RESET_TRANSITION_ALTITUDE;
         cfg_ff.cruise_altitude     <= tcap_pkg::RESET_CRUISE_ALTITUDE;
         cfg_ff.throttle_ceiling    <= tcap_pkg::RESET_THROTTLE_CEILING;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hw/rtl/tcap_law.sv @@
module tcap_law (
   input  tcap_pkg::flight_mode_type mode,
   input  tcap_pkg::req_word_type    req_word,
   input  tcap_pkg::cfg_type         cfg,
   output tcap_pkg::rsp_word_type    rsp_word,
   output logic                      to_cruise
);

   logic signed [32:0] neg_roll;
   logic signed [62:0] roll_prod;
   logic signed [31:0] roll_cmd;
   logic signed [32:0] alt_diff;
   logic signed [53:0] alt_prod;
   logic signed [31:0] cruise_elev;
   logic signed [31:0] step_left;
   logic signed [31:0] step_right;
   logic               below_ceiling;
   logic               on_runway;
   logic               climbing;
   logic               throttle_step;

   assign neg_roll    = -$signed({req_word.roll_angle[31], req_word.roll_angle});
   assign roll_prod   = neg_roll * tcap_pkg::ROLL_GAIN;
   assign roll_cmd    = (req_word.roll_angle == 32'sd0) ? req_word.aileron_now
                                                        : {roll_prod[62], roll_prod[62:32]};
   assign alt_diff    = $signed({req_word.altitude_now[31], req_word.altitude_now})
                        - $signed({2'b00, cfg.cruise_altitude});
   assign alt_prod    = alt_diff * tcap_pkg::ALT_GAIN;
   assign cruise_elev = {{10{alt_prod[53]}}, alt_prod[53:32]};

   assign below_ceiling = $signed({req_word.throttle_left_now[31], req_word.throttle_left_now})
                          < $signed({16'd0, cfg.throttle_ceiling});
   assign step_left  = tcap_pkg::sat_add(req_word.throttle_left_now, tcap_pkg::K_01);
   assign step_right = tcap_pkg::sat_add(req_word.throttle_right_now, tcap_pkg::K_01);
   assign on_runway  = (req_word.sink_speed > -tcap_pkg::K_ONE)
                       && (req_word.sink_speed < tcap_pkg::K_ONE)
                       && (req_word.air_speed < tcap_pkg::K_AS120);
   assign climbing   = (req_word.sink_speed < -tcap_pkg::K_TENTH)
                       || (req_word.air_speed > tcap_pkg::K_AS121);
   assign to_cruise  = (mode == tcap_pkg::MODE_TAKEOFF)
                       && ($signed({req_word.altitude_now[31], req_word.altitude_now})
                           >= $signed({2'b00, cfg.transition_altitude}));

   always_comb begin
      rsp_word.aileron_cmd        = req_word.aileron_now;
      rsp_word.elevator_cmd       = req_word.elevator_now;
      rsp_word.rudder_cmd         = req_word.rudder_now;
      rsp_word.throttle_left_cmd  = req_word.throttle_left_now;
      rsp_word.throttle_right_cmd = req_word.throttle_right_now;
      rsp_word.mode_used          = mode;
      throttle_step               = 1'b0;
      if (mode == tcap_pkg::MODE_TAKEOFF) begin
         if (on_runway) begin
            if (req_word.north_speed < -tcap_pkg::K_0005) begin
               if (req_word.north_accel < tcap_pkg::K_0001) begin
                  rsp_word.rudder_cmd = tcap_pkg::sat_add(req_word.rudder_now, -tcap_pkg::K_001);
               end
            end else if (req_word.north_speed > tcap_pkg::K_0005) begin
               if (req_word.north_accel > -tcap_pkg::K_0001) begin
                  rsp_word.rudder_cmd = tcap_pkg::sat_add(req_word.rudder_now, tcap_pkg::K_001);
               end
            end
            throttle_step = 1'b1;
         end else begin
            if (req_word.north_speed < -tcap_pkg::K_005) begin
               if (req_word.north_accel < tcap_pkg::K_01) begin
                  rsp_word.rudder_cmd = tcap_pkg::sat_add(req_word.rudder_now, -tcap_pkg::K_005);
               end
            end else if (req_word.north_speed > tcap_pkg::K_005) begin
               if (req_word.north_accel > -tcap_pkg::K_01) begin
                  rsp_word.rudder_cmd = tcap_pkg::sat_add(req_word.rudder_now, tcap_pkg::K_005);
               end
            end
         end
         if (climbing) begin
            if (req_word.elevator_now > -tcap_pkg::K_TENTH) begin
               rsp_word.elevator_cmd = tcap_pkg::sat_add(req_word.elevator_now, -tcap_pkg::K_001);
               throttle_step = 1'b1;
            end else if (req_word.elevator_now > -tcap_pkg::K_FIFTH) begin
               rsp_word.elevator_cmd = tcap_pkg::sat_add(req_word.elevator_now, -tcap_pkg::K_0001);
               throttle_step = 1'b1;
            end
            rsp_word.aileron_cmd = roll_cmd;
         end
         if (throttle_step && below_ceiling) begin
            rsp_word.throttle_left_cmd  = step_left;
            rsp_word.throttle_right_cmd = step_right;
         end
      end else begin
         rsp_word.aileron_cmd        = roll_cmd;
         rsp_word.elevator_cmd       = cruise_elev;
         rsp_word.rudder_cmd         = 32'sd0;
         rsp_word.throttle_left_cmd  = $signed({15'd0, cfg.throttle_ceiling});
         rsp_word.throttle_right_cmd = $signed({15'd0, cfg.throttle_ceiling});
      end
   end

endmodule

@@ hw/rtl/tcap_checker.sv @@
module tcap_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input tcap_pkg::rsp_word_type rsp_word
);

   logic rsp_take;
   logic seen_cruise_ff;
   logic seen_cruise_in;

   assign rsp_take       = rsp_valid && rsp_ready;
   assign seen_cruise_in = seen_cruise_ff || (rsp_take && rsp_word.mode_used);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_cruise_ff <= 1'b0;
      end else begin
         seen_cruise_ff <= seen_cruise_in;
      end
   end

   // a pending word holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("response word dropped or changed while stalled");

   // a free output side never blocks the input
   a_req_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with output register empty");

   // mode never goes back to takeoff without reset
   a_mode_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_take && seen_cruise_ff |-> rsp_word.mode_used)
      else $error("takeoff rule after cruise");

   // cruise centers rudder and sets equal throttles
   a_cruise_word: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_word.mode_used |->
         rsp_word.rudder_cmd == 32'sd0
         && rsp_word.throttle_left_cmd == rsp_word.throttle_right_cmd)
      else $error("bad cruise response word");

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind takeoff_cruise_autopilot_step tcap_checker u_tcap_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_word  (rsp_if.word)
);

@@ tb/takeoff_cruise_autopilot_step_tb.sv @@
`timescale 1ns / 100ps

module takeoff_cruise_autopilot_step_tb;

   localparam int S32_TOP    = 32'sh7fff_ffff;
   localparam int S32_BOTTOM = 32'sh8000_0000;

   // q16.16 thresholds and steps
   localparam int C_0P0001 = 7;
   localparam int C_0P0005 = 33;
   localparam int C_0P001  = 66;
   localparam int C_0P005  = 328;
   localparam int C_0P01   = 655;
   localparam int C_0P1    = 6554;
   localparam int C_0P2    = 13107;
   localparam int C_ONE    = 65536;
   localparam int C_KT120  = 7864320;
   localparam int C_KT121  = 7929856;

   // gains as q0.32
   localparam longint ROLL_GAIN_Q32 = 64'sd429496730;
   localparam longint ALT_GAIN_Q32  = 64'sd644245;

   localparam int LONG_HOLD     = 120;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int CLIMB_ALT     = 196608000;

   logic clock;
   logic reset;

   tcap_req_if req_bus ();
   tcap_rsp_if rsp_bus ();
   tcap_csr_if csr_bus ();

   takeoff_cruise_autopilot_step dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   tcap_pkg::flight_mode_type model_mode       = tcap_pkg::MODE_TAKEOFF;
   logic [30:0]               model_transition = 31'd196608000;
   logic [30:0]               model_cruise_alt = 31'd283967488;
   logic [16:0]               model_ceiling    = 17'd39322;

   tcap_pkg::req_word_type pending_samples [$];
   tcap_pkg::rsp_word_type expected_cmds [$];

   int req_offered;
   int req_accepted;
   int req_gap;
   int rsp_hold_left;
   int stall_requests;
   int stall_served;
   int quiet_cycles;
   int error_count;
   bit req_idle_on;
   bit rsp_idle_on;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic int clamp32(longint v);
      if (v > 64'sd2147483647) return S32_TOP;
      if (v < -64'sd2147483648) return S32_BOTTOM;
      return int'(v);
   endfunction

   function automatic int roll_cmd(int roll, int current);
      if (roll == 0) return current;
      return clamp32((-(longint'(roll) * ROLL_GAIN_Q32)) >>> 32);
   endfunction

   function automatic tcap_pkg::rsp_word_type autopilot_cmds(tcap_pkg::req_word_type s);
      tcap_pkg::rsp_word_type r;
      int sink, aspd, nspd, nacc, roll, alt, ail, elev, rud, thl, thr;
      int thl_up, thr_up;
      bit below, runway;
      longint diff;
      sink = s.sink_speed;
      aspd = s.air_speed;
      nspd = s.north_speed;
      nacc = s.north_accel;
      roll = s.roll_angle;
      alt  = s.altitude_now;
      ail  = s.aileron_now;
      elev = s.elevator_now;
      rud  = s.rudder_now;
      thl  = s.throttle_left_now;
      thr  = s.throttle_right_now;
      r.aileron_cmd        = ail;
      r.elevator_cmd       = elev;
      r.rudder_cmd         = rud;
      r.throttle_left_cmd  = thl;
      r.throttle_right_cmd = thr;
      r.mode_used          = model_mode;
      below  = longint'(thl) < longint'(model_ceiling);
      thl_up = clamp32(longint'(thl) + C_0P01);
      thr_up = clamp32(longint'(thr) + C_0P01);
      if (model_mode == tcap_pkg::MODE_TAKEOFF) begin
         runway = sink > -C_ONE && sink < C_ONE && aspd < C_KT120;
         if (runway) begin
            if (nspd < -C_0P0005) begin
               if (nacc < C_0P0001) r.rudder_cmd = clamp32(longint'(rud) - C_0P001);
            end else if (nspd > C_0P0005) begin
               if (nacc > -C_0P0001) r.rudder_cmd = clamp32(longint'(rud) + C_0P001);
            end
            if (below) begin
               r.throttle_left_cmd  = thl_up;
               r.throttle_right_cmd = thr_up;
            end
         end else begin
            if (nspd < -C_0P005) begin
               if (nacc < C_0P01) r.rudder_cmd = clamp32(longint'(rud) - C_0P005);
            end else if (nspd > C_0P005) begin
               if (nacc > -C_0P01) r.rudder_cmd = clamp32(longint'(rud) + C_0P005);
            end
         end
         // climbing or fast: elevator eases down, one throttle step at most
         if (sink < -C_0P1 || aspd > C_KT121) begin
            if (elev > -C_0P1 || elev > -C_0P2) begin
               r.elevator_cmd = clamp32(longint'(elev) - ((elev > -C_0P1) ? C_0P001 : C_0P0001));
               if (below) begin
                  r.throttle_left_cmd  = thl_up;
                  r.throttle_right_cmd = thr_up;
               end
            end
            r.aileron_cmd = roll_cmd(roll, ail);
         end
         if (longint'(alt) >= longint'(model_transition)) model_mode = tcap_pkg::MODE_CRUISE;
      end else begin
         diff = longint'(alt) - longint'(model_cruise_alt);
         r.aileron_cmd        = roll_cmd(roll, ail);
         r.elevator_cmd       = clamp32((diff * ALT_GAIN_Q32) >>> 32);
         r.rudder_cmd         = 0;
         r.throttle_left_cmd  = int'(model_ceiling);
         r.throttle_right_cmd = int'(model_ceiling);
      end
      return r;
   endfunction

   function automatic int jitter(int center, int span);
      return center + int'($urandom_range(2 * span, 0)) - span;
   endfunction

   function automatic int pick(int near_a, int near_b, int span, int wide);
      case ($urandom_range(7, 0))
         0, 1: return jitter(near_a, span);
         2, 3: return jitter(near_b, span);
         4, 5: return jitter(0, wide);
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_gap(bit enabled);
      int unsigned r;
      if (!enabled) return 0;
      r = $urandom_range(99, 0);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   function automatic tcap_pkg::req_word_type takeoff_sample();
      tcap_pkg::req_word_type s;
      int alt;
      if ($urandom_range(1, 0)) begin
         s.sink_speed = jitter(0, C_ONE - 1);
         s.air_speed  = jitter(0, C_KT120 - 1);
      end else begin
         s.sink_speed = pick(-C_ONE, C_ONE, 2, C_ONE);
         s.air_speed  = pick(C_KT120, C_KT121, 2, C_KT120);
      end
      if ($urandom_range(1, 0)) begin
         s.north_speed = pick(-C_0P0005, C_0P0005, 2, 400);
         s.north_accel = pick(-C_0P0001, C_0P0001, 2, 800);
      end else begin
         s.north_speed = pick(-C_0P005, C_0P005, 2, 400);
         s.north_accel = pick(-C_0P01, C_0P01, 2, 800);
      end
      // keep altitude under the switch point so takeoff mode persists
      if (model_transition == 0) begin
         alt = $urandom | 32'h8000_0000;
      end else begin
         case ($urandom_range(2, 0))
            0: alt = int'(model_transition) - int'($urandom_range(1000, 1));
            1: alt = int'($urandom_range(model_transition - 1, 0));
            default: alt = $urandom | 32'h8000_0000;
         endcase
      end
      s.roll_angle         = pick(0, S32_BOTTOM, 1, 1 << 22);
      s.altitude_now       = alt;
      s.aileron_now        = $urandom;
      s.elevator_now       = pick(-C_0P1, -C_0P2, 2, 20000);
      s.rudder_now         = pick(S32_BOTTOM + 200, S32_TOP - 200, 250, 1000);
      s.throttle_left_now  = pick(int'(model_ceiling), S32_TOP - 300, 2, 80000);
      s.throttle_right_now = pick(S32_TOP - 300, S32_BOTTOM, 400, 80000);
      return s;
   endfunction

   function automatic tcap_pkg::req_word_type cruise_sample();
      tcap_pkg::req_word_type s;
      s.sink_speed         = $urandom;
      s.air_speed          = $urandom;
      s.north_speed        = $urandom;
      s.north_accel        = $urandom;
      s.roll_angle         = pick(0, S32_BOTTOM, 1, 1 << 22);
      s.altitude_now       = pick(int'(model_cruise_alt), S32_TOP, 2, 1 << 24);
      s.aileron_now        = $urandom;
      s.elevator_now       = $urandom;
      s.rudder_now         = $urandom;
      s.throttle_left_now  = $urandom;
      s.throttle_right_now = $urandom;
      return s;
   endfunction

   function automatic void add_sample(int sink, int air, int nspd, int nacc, int roll,
                                      int alt, int elev, int rud, int thl, int thr);
      tcap_pkg::req_word_type s;
      s.sink_speed         = sink;
      s.air_speed          = air;
      s.north_speed        = nspd;
      s.north_accel        = nacc;
      s.roll_angle         = roll;
      s.altitude_now       = alt;
      s.aileron_now        = $urandom;
      s.elevator_now       = elev;
      s.rudder_now         = rud;
      s.throttle_left_now  = thl;
      s.throttle_right_now = thr;
      pending_samples.push_back(s);
   endfunction

   task automatic report_mismatch(string what);
      $display("[%0t] %s", $time, what);
      error_count++;
   endtask

   task automatic write_reg(tcap_pkg::csr_index_type which, logic [31:0] data);
      @(negedge clock);
      csr_bus.valid      <= 1'b1;
      csr_bus.word.index <= which;
      csr_bus.word.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_samples.size() != 0 || req_accepted != req_offered ||
             expected_cmds.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // sample driver
   always @(negedge clock) begin
      if (req_bus.valid && req_accepted != req_offered) begin
         // word still waiting for ready
      end else if (req_gap > 0) begin
         req_bus.valid <= 1'b0;
         req_gap--;
      end else if (pending_samples.size() != 0) begin
         req_bus.word  <= pending_samples.pop_front();
         req_bus.valid <= 1'b1;
         req_offered++;
         req_gap = pick_gap(req_idle_on);
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // command receiver
   always @(negedge clock) begin
      if (stall_requests != stall_served) begin
         stall_served  = stall_requests;
         rsp_hold_left = LONG_HOLD;
      end
      if (rsp_hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold_left--;
      end else if (rsp_idle_on && $urandom_range(99, 0) < 25) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold_left = pick_gap(1'b1);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      tcap_pkg::rsp_word_type got, want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = rsp_bus.word;
            if (expected_cmds.size() == 0) begin
               report_mismatch($sformatf("command word %h with no sample outstanding", got));
            end else begin
               want = expected_cmds.pop_front();
               if (got.aileron_cmd !== want.aileron_cmd)
                  report_mismatch($sformatf("aileron_cmd %h, expected %h",
                                            got.aileron_cmd, want.aileron_cmd));
               if (got.elevator_cmd !== want.elevator_cmd)
                  report_mismatch($sformatf("elevator_cmd %h, expected %h",
                                            got.elevator_cmd, want.elevator_cmd));
               if (got.rudder_cmd !== want.rudder_cmd)
                  report_mismatch($sformatf("rudder_cmd %h, expected %h",
                                            got.rudder_cmd, want.rudder_cmd));
               if (got.throttle_left_cmd !== want.throttle_left_cmd)
                  report_mismatch($sformatf("throttle_left_cmd %h, expected %h",
                                            got.throttle_left_cmd, want.throttle_left_cmd));
               if (got.throttle_right_cmd !== want.throttle_right_cmd)
                  report_mismatch($sformatf("throttle_right_cmd %h, expected %h",
                                            got.throttle_right_cmd, want.throttle_right_cmd));
               if (got.mode_used !== want.mode_used)
                  report_mismatch($sformatf("mode_used %b, expected %b",
                                            got.mode_used, want.mode_used));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            expected_cmds.push_back(autopilot_cmds(req_bus.word));
            req_accepted++;
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.word.index)
               tcap_pkg::CSR_TRANSITION_ALTITUDE: model_transition = csr_bus.word.data[30:0];
               tcap_pkg::CSR_CRUISE_ALTITUDE:     model_cruise_alt = csr_bus.word.data[30:0];
               tcap_pkg::CSR_THROTTLE_CEILING:    model_ceiling    = csr_bus.word.data[16:0];
               default: ;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles = 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("no handshake for %0d cycles", quiet_cycles);
         $display("[takeoff_cruise_autopilot_step] ERROR");
         $finish;
      end else begin
         quiet_cycles++;
      end
   end

   initial begin
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.word  = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.word  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // takeoff, switch point out of reach, masked register data
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      write_reg(tcap_pkg::CSR_TRANSITION_ALTITUDE, 32'hffff_ffff);
      write_reg(tcap_pkg::CSR_CRUISE_ALTITUDE, 32'h0);
      write_reg(tcap_pkg::CSR_THROTTLE_CEILING, 32'd39322);
      write_reg(tcap_pkg::CSR_UNUSED, 32'hffff_ffff);
      add_sample(0, 0, -34, 6, 1000, 0, 0, 0, 0, 0);
      add_sample(0, 0, -34, 7, 0, 0, 0, 0, 39321, 5);
      add_sample(0, 0, 34, -6, 0, 0, 0, 0, 39322, 0);
      add_sample(0, 0, 33, 0, 0, 0, 0, 0, S32_TOP, 0);
      add_sample(0, 0, -33, -7, 0, 0, 0, S32_BOTTOM, S32_BOTTOM, S32_TOP);
      add_sample(C_ONE, 0, -329, 654, 0, 0, 0, S32_BOTTOM + 100, 0, 0);
      add_sample(-C_ONE, 0, 329, -654, 0, 0, 0, S32_TOP - 100, 0, 0);
      add_sample(0, C_KT120, 328, 655, 5, 0, -6554, 0, 0, 0);
      add_sample(-6555, 0, -328, 0, -1, 0, -6553, 0, 0, 0);
      add_sample(0, C_KT121 + 1, 0, 0, S32_BOTTOM, 0, -6554, 0, 0, 0);
      add_sample(-6554, C_KT121, 0, 0, 1234, 0, 0, 0, 0, 0);
      add_sample(-6555, C_KT121, 0, 0, 0, 0, -13107, 0, 0, 0);
      add_sample(-7000, 0, 0, 0, S32_TOP, 0, -13106, 0, 38000, S32_TOP);
      add_sample(-65535, C_KT120 - 1, 0, 0, 0, S32_BOTTOM, S32_TOP, 0, 0, 0);
      add_sample(S32_TOP, S32_TOP, S32_TOP, S32_TOP, S32_TOP, S32_TOP - 1, S32_TOP,
                 S32_TOP, S32_TOP, S32_TOP);
      add_sample(S32_BOTTOM, S32_BOTTOM, S32_BOTTOM, S32_BOTTOM, S32_BOTTOM, S32_BOTTOM,
                 S32_BOTTOM, S32_BOTTOM, S32_BOTTOM, S32_BOTTOM);
      repeat (110) pending_samples.push_back(takeoff_sample());
      // long receiver stall while samples keep coming
      stall_requests++;
      drain();

      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      write_reg(tcap_pkg::CSR_THROTTLE_CEILING, 32'h0);
      repeat (90) pending_samples.push_back(takeoff_sample());
      drain();

      // switch point zero: only negative altitudes stay in takeoff
      req_idle_on = 1'b1;
      write_reg(tcap_pkg::CSR_TRANSITION_ALTITUDE, 32'h8000_0000);
      write_reg(tcap_pkg::CSR_THROTTLE_CEILING, 32'd65536);
      repeat (90) pending_samples.push_back(takeoff_sample());
      drain();

      req_idle_on = 1'b0;
      rsp_idle_on = 1'b1;
      write_reg(tcap_pkg::CSR_TRANSITION_ALTITUDE, CLIMB_ALT);
      write_reg(tcap_pkg::CSR_THROTTLE_CEILING, 32'd39322);
      repeat (80) pending_samples.push_back(takeoff_sample());
      add_sample(0, 0, 0, 0, 0, CLIMB_ALT - 1, 0, 0, 0, 0);
      add_sample(0, 0, 0, 0, 0, CLIMB_ALT, 0, 0, 0, 0);
      drain();

      // cruise from here on
      req_idle_on = 1'b1;
      write_reg(tcap_pkg::CSR_CRUISE_ALTITUDE, 32'hffff_ffff);
      write_reg(tcap_pkg::CSR_THROTTLE_CEILING, 32'hffff_ffff);
      add_sample(0, 0, 0, 0, 0, S32_BOTTOM, 0, 0, 0, 0);
      add_sample(0, 0, 0, 0, S32_BOTTOM, S32_TOP, 0, 0, 0, 0);
      repeat (60) pending_samples.push_back(cruise_sample());
      stall_requests++;
      drain();

      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      write_reg(tcap_pkg::CSR_CRUISE_ALTITUDE, 32'h0);
      write_reg(tcap_pkg::CSR_THROTTLE_CEILING, 32'h0);
      add_sample(0, 0, 0, 0, S32_TOP, S32_TOP, 0, 0, 0, 0);
      add_sample(0, 0, 0, 0, 0, S32_BOTTOM, 0, 0, 0, 0);
      repeat (60) pending_samples.push_back(cruise_sample());
      drain();

      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      write_reg(tcap_pkg::CSR_CRUISE_ALTITUDE, 32'd283967488);
      write_reg(tcap_pkg::CSR_THROTTLE_CEILING, 32'd65536);
      repeat (60) pending_samples.push_back(cruise_sample());
      drain();
      repeat (8) @(posedge clock);

      if (expected_cmds.size() != 0)
         report_mismatch($sformatf("%0d command words never arrived", expected_cmds.size()));
      if (error_count == 0) begin
         $display("[takeoff_cruise_autopilot_step] OK");
      end else begin
         $display("[takeoff_cruise_autopilot_step] ERROR");
      end
      $finish;
   end

endmodule
